FILE: hw/rtl/dow_pkg.sv
package dow_pkg;

    localparam logic [7:0]  UNLOCK_FIRST_RESET  = 8'd165;
    localparam logic [7:0]  UNLOCK_SECOND_RESET = 8'd90;
    localparam logic [15:0] TIMEOUT_RESET       = 16'd50;
    localparam logic [3:0]  REQUEST_BITS        = 4'hF;

    localparam int BIT_MASTER   = 0;
    localparam int BIT_PEDAL    = 1;
    localparam int BIT_AIRWHEEL = 2;
    localparam int BIT_DIGITAL  = 3;

    typedef enum logic [1:0] {
        REG_UNLOCK_FIRST  = 2'd0,
        REG_UNLOCK_SECOND = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] control_counter;
        logic [7:0] control_key_a;
        logic [7:0] control_key_b;
        logic [7:0] control_request;
        logic [7:0] pedal_counter;
        logic [7:0] airwheel_counter;
        logic [7:0] digital_counter;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  active_mask;
        logic [3:0]  requested_mask;
        logic [15:0] control_freshness;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  wanted;
        logic [15:0] age;
        logic        fresh;
    } ctl_status_t;

endpackage

FILE: hw/rtl/dow_frame_age.sv
module dow_frame_age (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  counter,
    input  logic [15:0] timeout,
    output logic        fresh
);

    logic [7:0]  seen_reg;
    logic [7:0]  seen_next;
    logic [15:0] age_reg;
    logic [15:0] age_next;

    always_comb
    begin
        seen_next = seen_reg;
        age_next  = age_reg;
        if (counter != seen_reg)
        begin
            seen_next = counter;
            age_next  = 16'd0;
        end
        else if (age_reg < timeout)
        begin
            age_next = age_reg + 16'd1;
        end
        fresh = (age_next < timeout);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 8'd0;
            age_reg  <= dow_pkg::TIMEOUT_RESET;
        end
        else if (advance)
        begin
            seen_reg <= seen_next;
            age_reg  <= age_next;
        end
    end

endmodule

FILE: hw/rtl/dow_control.sv
module dow_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          counter,
    input  logic [7:0]          key_a,
    input  logic [7:0]          key_b,
    input  logic [7:0]          request,
    input  logic [7:0]          unlock_first,
    input  logic [7:0]          unlock_second,
    input  logic [15:0]         timeout,
    output dow_pkg::ctl_status_t status
);

    logic [7:0]  seen_reg;
    logic [7:0]  seen_next;
    logic [3:0]  wanted_reg;
    logic [3:0]  wanted_next;
    logic [15:0] age_reg;
    logic [15:0] age_next;

    always_comb
    begin
        seen_next   = seen_reg;
        wanted_next = wanted_reg;
        age_next    = age_reg;
        if (counter != seen_reg)
        begin
            seen_next = counter;
            if (key_a == unlock_first && key_b == unlock_second)
            begin
                wanted_next = request[3:0] & dow_pkg::REQUEST_BITS;
                age_next    = 16'd0;
            end
            else
            begin
                wanted_next = 4'd0;
                age_next    = timeout;
            end
        end
        else if (age_reg < timeout)
        begin
            age_next = age_reg + 16'd1;
        end
        status.wanted = wanted_next;
        status.age    = age_next;
        status.fresh  = (age_next < timeout);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 8'd0;
            wanted_reg <= 4'd0;
            age_reg    <= dow_pkg::TIMEOUT_RESET;
        end
        else if (advance)
        begin
            seen_reg   <= seen_next;
            wanted_reg <= wanted_next;
            age_reg    <= age_next;
        end
    end

endmodule

FILE: hw/rtl/debug_override_watchdog.sv
// Debug override watchdog. Each input item is one task tick carrying the
// receive counters of the control, pedal, air/wheel and digital debug frames
// plus the first three control bytes; each item yields exactly one result
// item, and a new item is taken every cycle the output register is free or
// being drained. A changed control counter with matching unlock bytes
// latches the requested flags; a mismatch clears them and expires the
// control frame. The active mask is a requested, fresh master plus each
// requested source whose frame arrived within timeout_ticks ticks, or empty.
// Write the unlock bytes and timeout only while no item is in flight.
module debug_override_watchdog (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dow_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output dow_pkg::out_item_t out_item,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [7:0]  unlock_first_reg;
    logic [7:0]  unlock_second_reg;
    logic [15:0] timeout_reg;

    logic               out_valid_reg;
    dow_pkg::out_item_t out_item_reg;
    dow_pkg::out_item_t out_item_next;

    logic                 accept;
    dow_pkg::ctl_status_t ctl_status;
    logic                 pedal_fresh;
    logic                 airwheel_fresh;
    logic                 digital_fresh;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlock_first_reg  <= dow_pkg::UNLOCK_FIRST_RESET;
            unlock_second_reg <= dow_pkg::UNLOCK_SECOND_RESET;
            timeout_reg       <= dow_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (dow_pkg::reg_index_t'(cfg_index))
                dow_pkg::REG_UNLOCK_FIRST:  unlock_first_reg  <= cfg_data[7:0];
                dow_pkg::REG_UNLOCK_SECOND: unlock_second_reg <= cfg_data[7:0];
                dow_pkg::REG_TIMEOUT_TICKS: timeout_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    dow_control u_control (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .counter       (in_item.control_counter),
        .key_a         (in_item.control_key_a),
        .key_b         (in_item.control_key_b),
        .request       (in_item.control_request),
        .unlock_first  (unlock_first_reg),
        .unlock_second (unlock_second_reg),
        .timeout       (timeout_reg),
        .status        (ctl_status)
    );

    dow_frame_age u_pedal (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .counter (in_item.pedal_counter),
        .timeout (timeout_reg),
        .fresh   (pedal_fresh)
    );

    dow_frame_age u_airwheel (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .counter (in_item.airwheel_counter),
        .timeout (timeout_reg),
        .fresh   (airwheel_fresh)
    );

    dow_frame_age u_digital (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .counter (in_item.digital_counter),
        .timeout (timeout_reg),
        .fresh   (digital_fresh)
    );

    always_comb
    begin
        out_item_next.active_mask       = 4'd0;
        out_item_next.requested_mask    = ctl_status.wanted;
        out_item_next.control_freshness = ctl_status.age;
        if (ctl_status.wanted[dow_pkg::BIT_MASTER] && ctl_status.fresh)
        begin
            out_item_next.active_mask[dow_pkg::BIT_MASTER]   = 1'b1;
            out_item_next.active_mask[dow_pkg::BIT_PEDAL]    =
                ctl_status.wanted[dow_pkg::BIT_PEDAL] && pedal_fresh;
            out_item_next.active_mask[dow_pkg::BIT_AIRWHEEL] =
                ctl_status.wanted[dow_pkg::BIT_AIRWHEEL] && airwheel_fresh;
            out_item_next.active_mask[dow_pkg::BIT_DIGITAL]  =
                ctl_status.wanted[dow_pkg::BIT_DIGITAL] && digital_fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n) accept |=> out_valid_reg
    ) else $error("accepted item produced no result");

    a_active_needs_master: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.active_mask == 4'd0 ||
                           out_item_reg.active_mask[dow_pkg::BIT_MASTER])
    ) else $error("source active without master");

    a_active_within_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_item_reg.active_mask & ~out_item_reg.requested_mask) == 4'd0)
    ) else $error("active flag not requested");

    a_master_fresh: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.active_mask[dow_pkg::BIT_MASTER]) |->
            (out_item_reg.control_freshness < timeout_reg)
    ) else $error("master active on stale control frame");

endmodule
